// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define CHK_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent required in the cycle after the trigger.
`define CHK_NEXT(lbl, trig, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (post)) \
		else $error(msg);

`endif

// ===== rtl/md5hs_pkg.sv =====
// Types, constants and round helper functions of the MD5 stream hasher.
package md5hs_pkg;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;
	localparam logic [3:0][31:0] IV_ALL = {IV_D, IV_C, IV_B, IV_A};

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic CMD_ABSORB = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	localparam logic [31:0] K_TAB [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// digest handoff from core to output buffer
	typedef struct packed {
		logic            vld;
		logic [3:0][31:0] word;
	} dig_t;

	// message word index used by round r
	function automatic logic [3:0] g_idx(input logic [5:0] r);
		logic [3:0] g;
		case (r[5:4])
			2'd0: g = r[3:0];
			2'd1: g = 4'd5 * r[3:0] + 4'd1;
			2'd2: g = 4'd3 * r[3:0] + 4'd5;
			2'd3: g = 4'd7 * r[3:0];
			default: g = r[3:0];
		endcase
		return g;
	endfunction

	function automatic logic [4:0] rot_amt(input logic [5:0] r);
		logic [4:0] s;
		case ({r[5:4], r[1:0]})
			4'h0: s = 5'd7;
			4'h1: s = 5'd12;
			4'h2: s = 5'd17;
			4'h3: s = 5'd22;
			4'h4: s = 5'd5;
			4'h5: s = 5'd9;
			4'h6: s = 5'd14;
			4'h7: s = 5'd20;
			4'h8: s = 5'd4;
			4'h9: s = 5'd11;
			4'ha: s = 5'd16;
			4'hb: s = 5'd23;
			4'hc: s = 5'd6;
			4'hd: s = 5'd10;
			4'he: s = 5'd15;
			4'hf: s = 5'd21;
			default: s = 5'd7;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/md5_hash_stream_top.sv =====
// MD5 stream hasher top level.
//   channel  dir  handshake            payload
//   input    in   in_valid/in_ready    cmd, data_byte
//   output   out  out_valid/out_ready  digest_word, word_index, last_word
// Absorb items are taken one per cycle; the 64th byte of a block starts a
// compression (load, 64 rounds on one round unit, chain add).
// A finish item runs one such compression, or two when an extra length block is needed,
// then the digest moves to the output buffer and four items follow.
// The input stalls while a compression runs or while a finished digest waits for the buffer to free.
// Asynchronous reset restores the initial chaining words; no clearing pass is needed.
module md5_hash_stream_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [1:0]  word_index,
	output logic        last_word
);
	import md5hs_pkg::*;

	dig_t dig;
	logic dig_ready;

	md5hs_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.data_byte (data_byte),
		.dig       (dig),
		.dig_ready (dig_ready)
	);

	md5hs_obuf u_obuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.dig         (dig),
		.dig_ready   (dig_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);
endmodule

// ===== rtl/md5hs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module md5hs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/md5hs_core.sv =====
// Byte absorb, block word memory, padding view and 64-round compression sequencer.
module md5hs_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	input  logic [7:0]        data_byte,
	output md5hs_pkg::dig_t   dig,
	input  logic              dig_ready
);
	import md5hs_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PRIME = 3'd1;
	localparam logic [2:0] ST_ROUND = 3'd2;
	localparam logic [2:0] ST_ADD   = 3'd3;
	localparam logic [2:0] ST_HAND  = 3'd4;

	logic [2:0]       st_q;
	logic [5:0]       fill_q;
	logic [63:0]      len_q;
	logic [23:0]      acc_q;
	logic [3:0][31:0] ch_q;
	logic [31:0]      a_q, b_q, c_q, d_q;
	logic [5:0]       rnd_q;
	logic [4:0]       nw_q;
	logic             pad_en_q, len_en_q, fin_q, extra_q;
	logic [31:0]      pad_q;
	logic [3:0]       gd_q;

	logic        in_acc;
	logic        we;
	logic [3:0]  raddr;
	logic [31:0] rdata;
	logic [5:0]  rd_rnd;
	logic [31:0] w, f, sum, rot;
	logic [63:0] dbl;
	logic [31:0] pad_w;

	assign in_ready = (st_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign we       = in_acc && (cmd == CMD_ABSORB) && (fill_q[1:0] == 2'd3);
	assign rd_rnd   = (st_q == ST_PRIME) ? rnd_q : rnd_q + 6'd1;
	assign raddr    = g_idx(rd_rnd);

	md5hs_ram #(.WIDTH(32), .DEPTH(16)) u_blk (
		.clk   (clk),
		.we    (we),
		.waddr (fill_q[5:2]),
		.wdata ({data_byte, acc_q}),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		case (fill_q[1:0])
			2'd0: pad_w = {24'h0, PAD_BYTE};
			2'd1: pad_w = {16'h0, PAD_BYTE, acc_q[7:0]};
			2'd2: pad_w = {8'h0, PAD_BYTE, acc_q[15:0]};
			2'd3: pad_w = {PAD_BYTE, acc_q};
			default: pad_w = 32'h0;
		endcase
	end

	// message word as seen by the round: stored words, pad word, zeros, length
	always_comb begin
		if ({1'b0, gd_q} < nw_q) begin
			w = rdata;
		end else if (pad_en_q && ({1'b0, gd_q} == nw_q)) begin
			w = pad_q;
		end else if (len_en_q && (gd_q == 4'd14)) begin
			w = len_q[31:0];
		end else if (len_en_q && (gd_q == 4'd15)) begin
			w = len_q[63:32];
		end else begin
			w = 32'h0;
		end
	end

	always_comb begin
		case (rnd_q[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (b_q & d_q) | (c_q & ~d_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			2'd3: f = c_q ^ (b_q | ~d_q);
			default: f = 32'h0;
		endcase
		sum = a_q + f + w + K_TAB[rnd_q];
		dbl = {sum, sum} << rot_amt(rnd_q);
		rot = dbl[63:32];
	end

	assign dig.vld  = (st_q == ST_HAND);
	assign dig.word = ch_q;

	always_ff @(posedge clk) begin
		gd_q <= raddr;
		if (in_acc && (cmd == CMD_ABSORB)) begin
			case (fill_q[1:0])
				2'd0: acc_q[7:0]   <= data_byte;
				2'd1: acc_q[15:8]  <= data_byte;
				2'd2: acc_q[23:16] <= data_byte;
				default: acc_q <= acc_q;
			endcase
		end
		if (in_acc && (cmd == CMD_FINISH)) begin
			pad_q <= pad_w;
		end
		case (st_q)
			ST_PRIME: begin
				a_q <= ch_q[0];
				b_q <= ch_q[1];
				c_q <= ch_q[2];
				d_q <= ch_q[3];
			end
			ST_ROUND: begin
				a_q <= d_q;
				d_q <= c_q;
				c_q <= b_q;
				b_q <= b_q + rot;
			end
			default: begin
				a_q <= a_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			fill_q   <= 6'd0;
			len_q    <= 64'd0;
			ch_q     <= IV_ALL;
			rnd_q    <= 6'd0;
			nw_q     <= 5'd0;
			pad_en_q <= 1'b0;
			len_en_q <= 1'b0;
			fin_q    <= 1'b0;
			extra_q  <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (in_acc && (cmd == CMD_ABSORB)) begin
						fill_q <= fill_q + 6'd1;
						len_q  <= len_q + 64'd8;
						if (fill_q == 6'd63) begin
							nw_q     <= 5'd16;
							pad_en_q <= 1'b0;
							len_en_q <= 1'b0;
							fin_q    <= 1'b0;
							extra_q  <= 1'b0;
							rnd_q    <= 6'd0;
							st_q     <= ST_PRIME;
						end
					end else if (in_acc) begin
						nw_q     <= {1'b0, fill_q[5:2]};
						pad_en_q <= 1'b1;
						len_en_q <= (fill_q[5:3] != 3'd7);
						extra_q  <= (fill_q[5:3] == 3'd7);
						fin_q    <= 1'b1;
						rnd_q    <= 6'd0;
						st_q     <= ST_PRIME;
					end
				end
				ST_PRIME: begin
					st_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						st_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					ch_q[0] <= ch_q[0] + a_q;
					ch_q[1] <= ch_q[1] + b_q;
					ch_q[2] <= ch_q[2] + c_q;
					ch_q[3] <= ch_q[3] + d_q;
					if (extra_q) begin
						nw_q     <= 5'd0;
						pad_en_q <= 1'b0;
						len_en_q <= 1'b1;
						extra_q  <= 1'b0;
						st_q     <= ST_PRIME;
					end else if (fin_q) begin
						st_q <= ST_HAND;
					end else begin
						st_q <= ST_IDLE;
					end
				end
				ST_HAND: begin
					if (dig_ready) begin
						ch_q   <= IV_ALL;
						fill_q <= 6'd0;
						len_q  <= 64'd0;
						fin_q  <= 1'b0;
						st_q   <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

// ===== rtl/md5hs_obuf.sv =====
// Digest output buffer: holds four words and hands them out one item at a time.
module md5hs_obuf (
	input  logic            clk,
	input  logic            arst_n,
	input  md5hs_pkg::dig_t dig,
	output logic            dig_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [31:0]     digest_word,
	output logic [1:0]      word_index,
	output logic            last_word
);
	import md5hs_pkg::*;

	logic [3:0][31:0] dg_q;
	logic [1:0]       cnt_q;
	logic             busy_q;

	assign dig_ready   = !busy_q;
	assign out_valid   = busy_q;
	assign digest_word = dg_q[cnt_q];
	assign word_index  = cnt_q;
	assign last_word   = (cnt_q == 2'd3);

	always_ff @(posedge clk) begin
		if (dig.vld && !busy_q) begin
			dg_q <= dig.word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (dig.vld && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q && out_ready) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
				end
			end
		end
	end
endmodule

// ===== rtl/md5_hash_stream_chk.sv =====
// Port-level assertion checker for the MD5 stream hasher, bound to the top level.
`include "assert_macros.svh"

module md5_hash_stream_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        cmd,
	input logic [7:0]  data_byte,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] digest_word,
	input logic [1:0]  word_index,
	input logic        last_word
);
	import md5hs_pkg::*;

	logic in_acc, out_acc, out_hold;

	assign in_acc   = in_valid && in_ready;
	assign out_acc  = out_valid && out_ready;
	assign out_hold = out_valid && !out_ready;

	`CHK_NEXT(a_fin_stall, in_acc && (cmd == CMD_FINISH), !in_ready, "finish item not stalling input")
	`CHK_NEXT(a_burst, out_acc && !last_word, out_valid, "digest burst broken")
	`CHK_NEXT(a_idx_step, out_acc && !last_word, word_index == $past(word_index) + 2'd1, "index skip")
	`CHK_ASSERT(a_last_idx, out_valid |-> (last_word == (word_index == 2'd3)), "last flag off word D")
	`CHK_NEXT(a_hold, out_hold, out_valid && $stable({digest_word, word_index}), "stalled item changed")
endmodule

bind md5_hash_stream_top md5_hash_stream_chk u_chk (.*);
